// ----- rtl/core/ppm_pkg.sv -----
`default_nettype none

package ppm_pkg;

    localparam int WINDOW   = 7;
    localparam int VAL_W    = 8;
    localparam int POS_W    = 16;
    localparam int PIX_BITS = 16;
    localparam int AGE_W    = $clog2(WINDOW);
    localparam int INS_W    = $clog2(WINDOW);
    localparam int MID      = WINDOW / 2;
    localparam int AXIS_W   = ((VAL_W + POS_W + 7) / 8) * 8;

    typedef logic [WINDOW-1:0][VAL_W-1:0] t_val_row;
    typedef logic [WINDOW-1:0][AGE_W-1:0] t_age_row;
    typedef logic [WINDOW-2:0][VAL_W-1:0] t_kval_row;
    typedef logic [WINDOW-2:0][AGE_W-1:0] t_kage_row;

    typedef struct packed {
        logic     seen;
        t_age_row age;
        t_val_row val;
    } t_row;

    typedef struct packed {
        logic                en;
        logic [PIX_BITS-1:0] addr;
        t_row                row;
    } t_wr;

endpackage

`default_nettype wire

// ----- rtl/core/ppm_store.sv -----
`default_nettype none

module ppm_store
    import ppm_pkg::*;
(
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_rd_en,
    input  wire [PIX_BITS-1:0] i_rd_addr,
    input  t_wr                i_wr,
    output t_row               o_rd_row,
    output logic               o_byp_hit,
    output t_row               o_byp_row,
    output logic               o_clr_done
);

    t_row                r_mem [0:(1 << PIX_BITS)-1];
    t_row                r_rd_row;
    t_row                r_byp_row;
    logic                r_byp_hit;
    logic                r_clr_busy;
    logic [PIX_BITS-1:0] r_clr_addr;

    // After reset every row is swept once so that all seen bits read as clear.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            r_clr_addr <= r_clr_addr + 1'b1;
            if (r_clr_addr == '1) begin
                r_clr_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_clr_busy) begin
            r_mem[r_clr_addr] <= '0;
        end else if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.row;
        end
    end

    // A write landing in the same cycle as the read is caught here, since
    // the read returns the old contents.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_row  <= r_mem[i_rd_addr];
            r_byp_hit <= i_wr.en && (i_wr.addr == i_rd_addr);
            r_byp_row <= i_wr.row;
        end
    end

    assign o_rd_row   = r_rd_row;
    assign o_byp_hit  = r_byp_hit;
    assign o_byp_row  = r_byp_row;
    assign o_clr_done = !r_clr_busy;

endmodule

`default_nettype wire

// ----- rtl/core/ppm_evict.sv -----
`default_nettype none

module ppm_evict
    import ppm_pkg::*;
(
    input  wire              i_clk,
    input  wire              i_load,
    input  wire [VAL_W-1:0]  i_value,
    input  t_row             i_src,
    output t_kval_row        o_kval,
    output t_kage_row        o_kage,
    output logic [WINDOW-2:0] o_lt,
    output logic [VAL_W-1:0] o_value
);

    t_val_row          w_val;
    t_age_row          w_age;
    logic [INS_W-1:0]  w_oldest;
    t_kval_row         w_kval;
    t_kage_row         w_kage;
    logic [WINDOW-2:0] w_lt;

    t_kval_row         r_kval;
    t_kage_row         r_kage;
    logic [WINDOW-2:0] r_lt;
    logic [VAL_W-1:0]  r_value;

    // A first visit fills the window with the new value, ages in slot order.
    always_comb begin
        w_val = i_src.val;
        w_age = i_src.age;
        if (!i_src.seen) begin
            for (int k = 0; k < WINDOW; k++) begin
                w_val[k] = i_value;
                w_age[k] = AGE_W'(k);
            end
        end
    end

    // The first slot of age zero is the one dropped; slot 0 if there is none.
    always_comb begin
        w_oldest = '0;
        for (int k = WINDOW - 1; k >= 0; k--) begin
            if (w_age[k] == '0) begin
                w_oldest = INS_W'(k);
            end
        end
    end

    always_comb begin
        for (int j = 0; j < WINDOW - 1; j++) begin
            if (INS_W'(j) < w_oldest) begin
                w_kval[j] = w_val[j];
                w_kage[j] = w_age[j];
            end else begin
                w_kval[j] = w_val[j+1];
                w_kage[j] = w_age[j+1];
            end
            if (w_kage[j] != '0) begin
                w_kage[j] = w_kage[j] - 1'b1;
            end
            w_lt[j] = w_kval[j] < i_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_kval  <= w_kval;
            r_kage  <= w_kage;
            r_lt    <= w_lt;
            r_value <= i_value;
        end
    end

    assign o_kval  = r_kval;
    assign o_kage  = r_kage;
    assign o_lt    = r_lt;
    assign o_value = r_value;

endmodule

`default_nettype wire

// ----- rtl/core/ppm_insert.sv -----
`default_nettype none

module ppm_insert
    import ppm_pkg::*;
(
    input  t_kval_row         i_kval,
    input  t_kage_row         i_kage,
    input  wire [WINDOW-2:0]  i_lt,
    input  wire [VAL_W-1:0]   i_value,
    output t_row              o_row,
    output logic [VAL_W-1:0]  o_median
);

    logic [INS_W-1:0] w_ins;
    t_val_row         w_lo_val;
    t_age_row         w_lo_age;
    t_val_row         w_hi_val;
    t_age_row         w_hi_age;

    // The new value goes right after the last kept entry smaller than it,
    // so it lands before any equal values.
    always_comb begin
        w_ins = '0;
        for (int j = 0; j < WINDOW - 1; j++) begin
            if (i_lt[j]) begin
                w_ins = INS_W'(j + 1);
            end
        end
    end

    // Kept entries seen in place (lo) and shifted up by one slot (hi).
    always_comb begin
        w_lo_val = '0;
        w_lo_age = '0;
        w_hi_val = '0;
        w_hi_age = '0;
        for (int j = 0; j < WINDOW - 1; j++) begin
            w_lo_val[j]   = i_kval[j];
            w_lo_age[j]   = i_kage[j];
            w_hi_val[j+1] = i_kval[j];
            w_hi_age[j+1] = i_kage[j];
        end
    end

    always_comb begin
        o_row.seen = 1'b1;
        for (int k = 0; k < WINDOW; k++) begin
            if (INS_W'(k) < w_ins) begin
                o_row.val[k] = w_lo_val[k];
                o_row.age[k] = w_lo_age[k];
            end else if (INS_W'(k) == w_ins) begin
                o_row.val[k] = i_value;
                o_row.age[k] = AGE_W'(WINDOW - 1);
            end else begin
                o_row.val[k] = w_hi_val[k];
                o_row.age[k] = w_hi_age[k];
            end
        end
    end

    assign o_median = o_row.val[MID];

endmodule

`default_nettype wire

// ----- rtl/core/per_pixel_temporal_median_top.sv -----
`default_nettype none

// Temporal median per pixel: for every pixel index the block keeps the last
// seven values in a sorted window, drops the oldest, inserts the new one and
// returns the middle entry with the received index. One pixel is taken per
// clock while the output is not stalled; each pixel passes through window
// read, removal of the oldest entry, and insertion with write-back into the
// result register. All windows live in one memory with one read and
// one write per cycle; back-to-back pixels of the same index are forwarded
// inside the pipeline, so they do not slow it down. After reset a clearing
// pass walks the 65536 window rows, one per cycle, and no pixel is accepted
// until it is done.

module per_pixel_temporal_median_top
    import ppm_pkg::*;
(
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    // [7:0] pixel_value, [23:8] pixel_index
    input  wire [AXIS_W-1:0] i_s_axis_tdata,
    output logic             o_m_axis_tvalid,
    input  wire              i_m_axis_tready,
    // [7:0] median_value, [23:8] pixel_position
    output logic [AXIS_W-1:0] o_m_axis_tdata
);

    logic              w_clr_done;
    logic              w_accept;
    logic              w_a_adv;
    logic              w_b_adv;
    logic              w_a_ready;
    logic              w_b_ready;
    logic              w_c_ready;

    logic              r_a_v;
    logic              r_b_v;
    logic              r_c_v;
    logic [VAL_W-1:0]  r_a_value;
    logic [POS_W-1:0]  r_a_pos;
    logic [POS_W-1:0]  r_b_pos;
    logic [POS_W-1:0]  r_c_pos;
    logic [VAL_W-1:0]  r_c_median;

    t_row              w_rd_row;
    t_row              w_byp_row;
    logic              w_byp_hit;
    t_row              w_src;
    t_wr               w_wr;

    t_kval_row         w_kval;
    t_kage_row         w_kage;
    logic [WINDOW-2:0] w_lt;
    logic [VAL_W-1:0]  w_b_value;
    t_row              w_new_row;
    logic [VAL_W-1:0]  w_median;

    assign w_c_ready = !r_c_v || i_m_axis_tready;
    assign w_b_adv   = r_b_v && w_c_ready;
    assign w_b_ready = !r_b_v || w_c_ready;
    assign w_a_adv   = r_a_v && w_b_ready;
    assign w_a_ready = !r_a_v || w_b_ready;

    assign o_s_axis_tready = w_a_ready && w_clr_done;
    assign w_accept        = i_s_axis_tvalid && o_s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
            r_b_v <= 1'b0;
            r_c_v <= 1'b0;
        end else begin
            if (w_accept) begin
                r_a_v <= 1'b1;
            end else if (w_a_adv) begin
                r_a_v <= 1'b0;
            end
            if (w_a_adv) begin
                r_b_v <= 1'b1;
            end else if (w_b_adv) begin
                r_b_v <= 1'b0;
            end
            if (w_b_adv) begin
                r_c_v <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_c_v <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_a_value <= i_s_axis_tdata[VAL_W-1:0];
            r_a_pos   <= i_s_axis_tdata[VAL_W+POS_W-1:VAL_W];
        end
        if (w_a_adv) begin
            r_b_pos <= r_a_pos;
        end
        if (w_b_adv) begin
            r_c_pos    <= r_b_pos;
            r_c_median <= w_median;
        end
    end

    assign w_wr.en   = w_b_adv;
    assign w_wr.addr = r_b_pos[PIX_BITS-1:0];
    assign w_wr.row  = w_new_row;

    ppm_store u_store (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rd_en    (w_accept),
        .i_rd_addr  (i_s_axis_tdata[VAL_W+PIX_BITS-1:VAL_W]),
        .i_wr       (w_wr),
        .o_rd_row   (w_rd_row),
        .o_byp_hit  (w_byp_hit),
        .o_byp_row  (w_byp_row),
        .o_clr_done (w_clr_done)
    );

    // The pixel one stage ahead has not written its window yet; take its
    // updated row directly when it shares the index.
    always_comb begin
        priority if (r_b_v && (r_b_pos[PIX_BITS-1:0] == r_a_pos[PIX_BITS-1:0])) begin
            w_src = w_new_row;
        end else if (w_byp_hit) begin
            w_src = w_byp_row;
        end else begin
            w_src = w_rd_row;
        end
    end

    ppm_evict u_evict (
        .i_clk   (i_clk),
        .i_load  (w_a_adv),
        .i_value (r_a_value),
        .i_src   (w_src),
        .o_kval  (w_kval),
        .o_kage  (w_kage),
        .o_lt    (w_lt),
        .o_value (w_b_value)
    );

    ppm_insert u_insert (
        .i_kval   (w_kval),
        .i_kage   (w_kage),
        .i_lt     (w_lt),
        .i_value  (w_b_value),
        .o_row    (w_new_row),
        .o_median (w_median)
    );

    assign o_m_axis_tvalid = r_c_v;
    assign o_m_axis_tdata  = AXIS_W'({r_c_pos, r_c_median});

    a_no_accept_while_clearing: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        !w_clr_done |-> !o_s_axis_tready
    ) else $error("input taken during the clearing pass");

    a_clear_done_stays: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        w_clr_done |=> w_clr_done
    ) else $error("clearing pass restarted without reset");

    a_no_overwrite_of_held_result: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (r_c_v && !i_m_axis_tready) |-> !w_b_adv
    ) else $error("pending result overwritten");

    a_stage_a_moves_when_b_empty: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (r_a_v && !r_b_v) |-> w_a_adv
    ) else $error("stage A held with stage B empty");

    a_result_from_stage_b: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_c_v) |-> $past(w_b_adv)
    ) else $error("result appeared without a stage B transfer");

endmodule

`default_nettype wire
